/* hdl/icon4_pkg.sv */
// Shared constants, codes and color helpers for the tiled 4bpp icon converter.
`default_nettype none

package icon4_pkg;

  localparam int PALETTE_ENTRIES = 16;
  localparam int SLOT_W          = 4;
  localparam int COLOR_W         = 15;
  localparam int OFFSET_W        = 9;
  localparam int PAIR_W          = 8;
  localparam int ARGB_W          = 32;
  localparam int RASTER_W        = 10;
  localparam int TILE_SIDE       = 8;
  localparam int TILE_COUNT      = 16;

  localparam logic [7:0] OPAQUE_ALPHA = 8'hff;

  typedef enum logic {
    MODE_PALETTE = 1'b0,
    MODE_BITMAP  = 1'b1
  } mode_t;

  typedef logic [COLOR_W-1:0]  color_t;
  typedef logic [ARGB_W-1:0]   argb_t;
  typedef logic [RASTER_W-1:0] raster_t;

  // (c*33)>>2 is c replicated over its top three bits
  function automatic logic [7:0] expand_channel(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic argb_t rgb555_to_argb(input color_t color);
    return {OPAQUE_ALPHA,
            expand_channel(color[4:0]),
            expand_channel(color[9:5]),
            expand_channel(color[14:10])};
  endfunction

endpackage

`default_nettype wire

/* hdl/tiled_4bpp_icon_to_argb_top.sv */
// Tiled 4bpp icon converter: palette memory, lookup stage and two-pixel output stage.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+---------------------------------------------------
//  in      | in_valid / in_ready    | mode, palette_slot, color_word, byte_offset,
//          |                        | pixel_pair
//  out     | out_valid / out_ready  | argb_pixel, raster_index, last_pixel
//
//  A palette transaction writes the palette memory at its accept edge and yields nothing;
//  writes to slot zero are dropped. A bitmap transaction reads both nibbles from the
//  two-read-port palette memory at its accept edge; it then moves into the output register
//  once that is free, and the one-pixel output port shows the left pixel, then the right one.
//  The lookup stage can take a new byte while the output register still shows the last one.
//  Reset clears the palette valid bits; unwritten entries read as color zero.
//  Output stalls back up through the lookup stage to in_ready without loss.
`default_nettype none

module tiled_4bpp_icon_to_argb_top
  import icon4_pkg::*;
#(
  parameter int ICON_SIDE = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                mode,
  input  wire logic [SLOT_W-1:0]   palette_slot,
  input  wire logic [COLOR_W-1:0]  color_word,
  input  wire logic [OFFSET_W-1:0] byte_offset,
  input  wire logic [PAIR_W-1:0]   pixel_pair,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [ARGB_W-1:0]        argb_pixel,
  output logic [RASTER_W-1:0]      raster_index,
  output logic                     last_pixel
);

  localparam int TILES_PER_ROW = (ICON_SIDE / TILE_SIDE == 0) ? 1 : ICON_SIDE / TILE_SIDE;
  localparam raster_t SIDE_R   = RASTER_W'(ICON_SIDE);
  localparam raster_t TOP_ROW  = RASTER_W'(ICON_SIDE - 1);

  // Tile number to tile row / tile column, settled at elaboration
  function automatic logic [TILE_COUNT*4-1:0] build_lut(input bit want_row);
    logic [TILE_COUNT*4-1:0] lut;
    lut = '0;
    for (int i = 0; i < TILE_COUNT; i++) begin
      if (want_row) begin
        lut[i*4 +: 4] = 4'(i / TILES_PER_ROW);
      end else begin
        lut[i*4 +: 4] = 4'(i % TILES_PER_ROW);
      end
    end
    return lut;
  endfunction

  localparam logic [TILE_COUNT*4-1:0] TILE_ROW_LUT = build_lut(1'b1);
  localparam logic [TILE_COUNT*4-1:0] TILE_COL_LUT = build_lut(1'b0);

  // Handshake
  logic in_accept;
  logic pal_we;
  logic bm_accept;
  logic out_free;
  logic s1_move;

  // Palette memory and its valid bits
  color_t                     pal_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pal_valid;

  // Lookup stage
  logic    s1_valid;
  color_t  s1_rd0;
  color_t  s1_rd1;
  logic    s1_nz0;
  logic    s1_nz1;
  raster_t s1_base;

  // Output stage
  argb_t   out_pix0;
  argb_t   out_pix1;
  raster_t out_base;
  logic    out_phase;

  // Raster address of the left pixel
  logic [3:0] nib0;
  logic [3:0] nib1;
  logic [3:0] tile;
  logic [3:0] tile_row;
  logic [3:0] tile_col;
  raster_t    row_r;
  raster_t    col_r;
  raster_t    row_scaled;
  raster_t    base;

  assign nib0     = pixel_pair[3:0];
  assign nib1     = pixel_pair[7:4];
  assign tile     = byte_offset[8:5];
  assign tile_row = TILE_ROW_LUT[tile*4 +: 4];
  assign tile_col = TILE_COL_LUT[tile*4 +: 4];

  always_comb begin
    row_r      = TOP_ROW - {3'b0, tile_row, 3'b0} - {7'b0, byte_offset[4:2]};
    col_r      = {3'b0, tile_col, 3'b0} + {7'b0, byte_offset[1:0], 1'b0};
    row_scaled = row_r * SIDE_R;
    base       = row_scaled + col_r;
  end

  assign out_free  = !out_valid || (out_ready && out_phase);
  assign s1_move   = s1_valid && out_free;
  assign in_ready  = !s1_valid || s1_move;
  assign in_accept = in_valid && in_ready;
  assign pal_we    = in_accept && (mode == MODE_PALETTE) && (palette_slot != '0);
  assign bm_accept = in_accept && (mode == MODE_BITMAP);

  // Palette memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[palette_slot] <= color_word;
    end
  end

  // Unwritten entries give color zero; only index 0 is transparent
  always_ff @(posedge clk) begin
    if (bm_accept) begin
      s1_rd0  <= pal_valid[nib0] ? pal_mem[nib0] : '0;
      s1_rd1  <= pal_valid[nib1] ? pal_mem[nib1] : '0;
      s1_nz0  <= (nib0 != '0);
      s1_nz1  <= (nib1 != '0);
      s1_base <= base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
    end else if (pal_we) begin
      pal_valid[palette_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bm_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Output stage: expand colors on the way in, then show left and right pixel
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pix0 <= s1_nz0 ? rgb555_to_argb(s1_rd0) : '0;
      out_pix1 <= s1_nz1 ? rgb555_to_argb(s1_rd1) : '0;
      out_base <= s1_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_phase <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
      out_phase <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (out_phase) begin
        out_valid <= 1'b0;
        out_phase <= 1'b0;
      end else begin
        out_phase <= 1'b1;
      end
    end
  end

  assign argb_pixel   = out_phase ? out_pix1 : out_pix0;
  assign raster_index = out_base + {{(RASTER_W-1){1'b0}}, out_phase};
  assign last_pixel   = out_phase;

  // The right pixel follows the left one at the next column
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_pixel
    |=> out_valid && last_pixel && (raster_index == $past(raster_index) + 10'd1))
    else $error("right pixel did not follow left pixel");

  // A palette write never enters the lookup stage
  a_palette_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == MODE_PALETTE) |=> !s1_valid)
    else $error("palette transaction produced a lookup");

  // Slot zero is never marked as written
  a_slot0_clear: assert property (@(posedge clk) disable iff (rst)
    !pal_valid[0])
    else $error("palette slot zero was written");

  // A finished lookup moves to the output register as soon as it is free
  a_lookup_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_free |=> out_valid && !out_phase)
    else $error("lookup stage failed to advance");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the tiled 4bpp icon to ARGB8888 converter.
module tb;
  import icon4_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ICON_SIDE    = 32;
  localparam int TILES_ACROSS = (ICON_SIDE / TILE_SIDE) > 0 ? ICON_SIDE / TILE_SIDE : 1;
  localparam int TILE_BYTES   = TILE_SIDE * TILE_SIDE / 2;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 100;

  typedef struct {
    mode_t                mode;
    logic [SLOT_W-1:0]    slot;
    logic [COLOR_W-1:0]   color;
    logic [OFFSET_W-1:0]  offset;
    logic [PAIR_W-1:0]    pair;
  } icon_item_t;

  typedef struct {
    argb_t   argb;
    raster_t raster;
    logic    last;
  } pixel_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                mode = 1'b0;
  logic [SLOT_W-1:0]   palette_slot = '0;
  logic [COLOR_W-1:0]  color_word = '0;
  logic [OFFSET_W-1:0] byte_offset = '0;
  logic [PAIR_W-1:0]   pixel_pair = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ARGB_W-1:0]   argb_pixel;
  logic [RASTER_W-1:0] raster_index;
  logic                last_pixel;

  icon_item_t  stimulus_q[$];
  pixel_t      pixels_due[$];
  color_t      shadow_palette [PALETTE_ENTRIES];

  int error_count   = 0;
  int report_count  = 0;
  int palette_count = 0;
  int slot0_count   = 0;
  int bitmap_count  = 0;
  int pixels_seen   = 0;

  tiled_4bpp_icon_to_argb_top #(.ICON_SIDE(ICON_SIDE)) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .palette_slot (palette_slot),
    .color_word   (color_word),
    .byte_offset  (byte_offset),
    .pixel_pair   (pixel_pair),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .argb_pixel   (argb_pixel),
    .raster_index (raster_index),
    .last_pixel   (last_pixel)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic logic [7:0] widen_channel(input logic [4:0] c);
    int unsigned v;
    v = int'(c) * 33;
    return 8'(v >> 2);
  endfunction

  function automatic argb_t palette_color(input logic [3:0] nibble);
    color_t c;
    if (nibble == 4'd0) return '0;
    c = shadow_palette[nibble];
    return {8'hff, widen_channel(c[4:0]), widen_channel(c[9:5]), widen_channel(c[14:10])};
  endfunction

  // bottom-up raster position of the left pixel of a bitmap byte
  function automatic int unsigned left_position(input logic [OFFSET_W-1:0] offset);
    int unsigned tile, tile_row, tile_col, in_tile, row, col;
    tile     = offset / TILE_BYTES;
    tile_row = tile / TILES_ACROSS;
    tile_col = tile % TILES_ACROSS;
    in_tile  = offset % TILE_BYTES;
    row      = ICON_SIDE - 1 - tile_row * TILE_SIDE - (in_tile >> 2);
    col      = tile_col * TILE_SIDE + ((in_tile & 3) << 1);
    return row * ICON_SIDE + col;
  endfunction

  task automatic apply_transaction(input icon_item_t it);
    pixel_t      px;
    int unsigned base;
    if (it.mode == MODE_PALETTE) begin
      palette_count++;
      if (it.slot == '0) slot0_count++;
      else shadow_palette[it.slot] = it.color;
    end else begin
      bitmap_count++;
      base = left_position(it.offset);
      for (int k = 0; k < 2; k++) begin
        px.argb   = palette_color(it.pair[4*k +: 4]);
        px.raster = raster_t'(base + k);
        px.last   = (k == 1);
        pixels_due.push_back(px);
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_item(input mode_t m, input int slot, input int color,
                           input int offset, input int pair);
    icon_item_t it;
    it.mode   = m;
    it.slot   = SLOT_W'(slot);
    it.color  = COLOR_W'(color);
    it.offset = OFFSET_W'(offset);
    it.pair   = PAIR_W'(pair);
    stimulus_q.push_back(it);
  endtask

  // ---------------------------------------------------------------- driver

  icon_item_t next_item;
  int         burst_left = 0;
  int         gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready)
        apply_transaction('{mode_t'(mode), palette_slot, color_word, byte_offset, pixel_pair});
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stimulus_q.size() > 0) begin
          next_item = stimulus_q.pop_front();
          in_valid     <= 1'b1;
          mode         <= next_item.mode;
          palette_slot <= next_item.slot;
          color_word   <= next_item.color;
          byte_offset  <= next_item.offset;
          pixel_pair   <= next_item.pair;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver stalls

  int ready_style = 0;
  int ready_phase = 0;
  int ready_hold  = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      ready_phase++;
      if (ready_phase % 97 == 0) ready_style = $urandom_range(0, 3);
      case (ready_style)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (ready_phase % 5) != 0;
        default: begin
          // long stalls followed by short open windows
          if (ready_hold > 0) begin
            ready_hold--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_hold = $urandom_range(1, 9);
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_field(input string field, input longint want, input longint got);
    error_count++;
    if (report_count < MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    report_count++;
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      pixels_seen++;
      if (pixels_due.size() == 0) begin
        error_count++;
        if (report_count < MAX_REPORTS)
          $display("%0t ns: unexpected pixel, expected none, actual argb 0x%08h raster %0d last %0b",
                   $time, argb_pixel, raster_index, last_pixel);
        report_count++;
      end else begin
        want = pixels_due.pop_front();
        if (argb_pixel !== want.argb) report_field("argb_pixel", want.argb, argb_pixel);
        if (raster_index !== want.raster) report_field("raster_index", want.raster, raster_index);
        if (last_pixel !== want.last) report_field("last_pixel", want.last, last_pixel);
      end
    end
  end

  // ---------------------------------------------------------------- run control

  initial begin
    #5_000_000;
    $display("Timeout at %0t ns", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int waited;
    for (int i = 0; i < PALETTE_ENTRIES; i++) shadow_palette[i] = '0;

    // unwritten entries read as zero color, index 0 as transparent zero
    push_item(MODE_BITMAP, 0, 0, 0, 8'hff);
    push_item(MODE_BITMAP, 0, 0, 511, 8'h10);
    // write to slot 0 must not take effect
    push_item(MODE_PALETTE, 0, 15'h7fff, 0, 0);
    push_item(MODE_BITMAP, 0, 0, 100, 8'h00);
    push_item(MODE_PALETTE, 15, 15'h7fff, 511, 8'hff);
    push_item(MODE_PALETTE, 1, 15'h001f, 0, 0);
    push_item(MODE_PALETTE, 2, 15'h03e0, 0, 0);
    push_item(MODE_PALETTE, 3, 15'h7c00, 0, 0);
    push_item(MODE_PALETTE, 8, 15'h5555, 0, 0);
    push_item(MODE_PALETTE, 7, 15'h2aaa, 0, 0);
    push_item(MODE_PALETTE, 4, 15'h0000, 0, 0);
    // palette fields on a bitmap transaction are ignored
    push_item(MODE_BITMAP, 5, 15'h7fff, 511, 8'hf1);
    push_item(MODE_BITMAP, 0, 0, 0, 8'h21);
    push_item(MODE_BITMAP, 0, 0, 3, 8'h83);
    push_item(MODE_BITMAP, 0, 0, 28, 8'h0f);
    push_item(MODE_BITMAP, 0, 0, 31, 8'hf0);
    push_item(MODE_BITMAP, 0, 0, 32, 8'h78);
    push_item(MODE_BITMAP, 0, 0, 255, 8'h47);
    push_item(MODE_BITMAP, 0, 0, 256, 8'h12);
    push_item(MODE_BITMAP, 0, 0, 480, 8'h3f);
    push_item(MODE_BITMAP, 0, 0, 9'h155, 8'h55);
    push_item(MODE_BITMAP, 0, 0, 9'h0aa, 8'haa);
    // overwrite an entry and read it straight back
    push_item(MODE_PALETTE, 15, 15'h1234, 0, 0);
    push_item(MODE_BITMAP, 0, 0, 200, 8'hff);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 3) == 0)
        push_item(MODE_PALETTE, $urandom_range(0, 15), $urandom_range(0, 32767),
                  $urandom_range(0, 511), $urandom_range(0, 255));
      else
        push_item(MODE_BITMAP, $urandom_range(0, 15), $urandom_range(0, 32767),
                  $urandom_range(0, 511), $urandom_range(0, 255));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // sample between edges so driver updates have settled
    waited = 0;
    while (in_valid || stimulus_q.size() != 0 || pixels_due.size() != 0) begin
      @(negedge clk);
      waited++;
      if (waited > DRAIN_LIMIT) begin
        $display("Drain timeout at %0t ns, %0d pixels outstanding", $time, pixels_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
    // watch for stray pixels after the last expected one
    repeat (16) @(posedge clk);

    $display("Covered %0d palette writes (%0d to slot 0) and %0d bitmap bytes, %0d pixels checked",
             palette_count, slot0_count, bitmap_count, pixels_seen);
    $display("%0d mismatches found", error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
